>>> design/eust_pkg.sv
// shared types, constants and weekday helper for the eu summer time detector
`timescale 1ns / 1ps
`default_nettype none

package eust_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic [MONTH_W-1:0]  MONTH_MAR  = 4'd3;
    localparam logic [MONTH_W-1:0]  MONTH_OCT  = 4'd10;
    localparam logic [HOUR_W-1:0]   HOUR_START = 5'd1;
    localparam logic [HOUR_W-1:0]   HOUR_END   = 5'd2;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

    // weekday of 25 march 2000, 0 is monday
    localparam logic [2:0] WD_MAR_BASE  = 3'd5;
    // 25 march to 25 october is 214 days, 4 mod 7
    localparam logic [2:0] WD_OCT_SHIFT = 3'd4;
    // first year since 2000 whose leap rule skips (2100)
    localparam logic [YEAR_W-1:0] YEAR_CENTURY = 7'd100;
    // day 25 plus days to sunday gives 31 minus weekday
    localparam logic [DAY_W-1:0] DAY_LAST = 5'd31;

    // field order gives tuple order when compared as a vector
    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_moment;

    // x mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s;
        logic [3:0] t;
        logic [3:0] r;
        s = 5'({3'b000, x[7:6]}) + 5'({2'b00, x[5:3]}) + 5'({2'b00, x[2:0]});
        t = 4'({2'b00, s[4:3]}) + 4'({1'b0, s[2:0]});
        r = (t >= 4'd7) ? (t - 4'd7) : t;
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

>>> design/eust_judge.sv
// combinational judge: last sundays of march and october, and the window compare
`timescale 1ns / 1ps
`default_nettype none

module eust_judge (
    input  wire eust_pkg::t_moment         i_now,
    input  wire [eust_pkg::YEAR_W-1:0]     i_year,
    output logic                           o_summer_time
);

    logic [4:0]                    leap_cnt;
    logic [7:0]                    wd_sum;
    logic [2:0]                    wd_mar;
    logic [2:0]                    wd_oct;
    logic [eust_pkg::DAY_W-1:0]    sun_mar;
    logic [eust_pkg::DAY_W-1:0]    sun_oct;
    eust_pkg::t_moment             start_mom;
    eust_pkg::t_moment             end_mom;

    always_comb begin
        // feb 29 days passed since 25 march 2000
        leap_cnt = i_year[6:2] - 5'((i_year >= eust_pkg::YEAR_CENTURY) ? 1 : 0);
        wd_sum   = 8'({5'b0, eust_pkg::WD_MAR_BASE}) + 8'({1'b0, i_year})
                   + 8'({3'b000, leap_cnt});
        wd_mar   = eust_pkg::mod7(wd_sum);
        wd_oct   = eust_pkg::mod7(8'({5'b0, wd_mar}) + 8'({5'b0, eust_pkg::WD_OCT_SHIFT}));
        sun_mar  = eust_pkg::DAY_LAST - 5'({2'b00, wd_mar});
        sun_oct  = eust_pkg::DAY_LAST - 5'({2'b00, wd_oct});

        start_mom.month  = eust_pkg::MONTH_MAR;
        start_mom.day    = sun_mar;
        start_mom.hour   = eust_pkg::HOUR_START;
        start_mom.minute = eust_pkg::MINUTE_MAX;
        start_mom.second = eust_pkg::SECOND_MAX;

        end_mom.month    = eust_pkg::MONTH_OCT;
        end_mom.day      = sun_oct;
        end_mom.hour     = eust_pkg::HOUR_END;
        end_mom.minute   = eust_pkg::MINUTE_MAX;
        end_mom.second   = eust_pkg::SECOND_MAX;

        o_summer_time = (i_now > start_mom) && (i_now <= end_mom);
    end

endmodule

`default_nettype wire

>>> design/eu_summer_time_detector.sv
// top level: input register, summer time judge and result register
`timescale 1ns / 1ps
`default_nettype none

// Tells whether European summer time is in force for one date and time (year
// counted from 2000, month, day, hour, minute, second). Summer time runs from
// after 01:59:59 on the last Sunday of March up to and including 02:59:59 on
// the last Sunday of October. Fields are used as raw bits with no calendar
// checks. One beat is accepted every cycle unless the input is back-pressured;
// the result is presented from the result register, with a single judge stage
// of combinational logic between the input register and it. A stall on the
// output holds the result register and, once both registers are full,
// back-pressures the input.
module eu_summer_time_detector (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [eust_pkg::YEAR_W-1:0]     i_year,
    input  wire [eust_pkg::MONTH_W-1:0]    i_month,
    input  wire [eust_pkg::DAY_W-1:0]      i_day,
    input  wire [eust_pkg::HOUR_W-1:0]     i_hour,
    input  wire [eust_pkg::MINUTE_W-1:0]   i_minute,
    input  wire [eust_pkg::SECOND_W-1:0]   i_second,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_summer_time
);

    logic                          r_in_valid;
    eust_pkg::t_moment             r_now;
    logic [eust_pkg::YEAR_W-1:0]   r_year;
    logic                          r_out_valid;
    logic                          r_summer_time;
    logic                          n_summer_time;
    logic                          out_en;
    logic                          in_en;

    assign out_en = !r_out_valid || !i_out_stall;
    assign in_en  = !r_in_valid || out_en;

    assign o_in_stall    = !in_en;
    assign o_out_valid   = r_out_valid;
    assign o_summer_time = r_summer_time;

    eust_judge u_judge (
        .i_now         (r_now),
        .i_year        (r_year),
        .o_summer_time (n_summer_time)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_valid <= i_in_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_en && i_in_valid) begin
            r_year       <= i_year;
            r_now.month  <= i_month;
            r_now.day    <= i_day;
            r_now.hour   <= i_hour;
            r_now.minute <= i_minute;
            r_now.second <= i_second;
        end
        if (out_en && r_in_valid) begin
            r_summer_time <= n_summer_time;
        end
    end

`ifndef SYNTHESIS
    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid set right after reset");

    a_beat_moves_on : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_en) |=> r_out_valid)
        else $error("input register beat lost");

    a_full_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while both registers are full");

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted beat not held in input register");

    a_winter_months : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_now.month < eust_pkg::MONTH_MAR
            || r_now.month > eust_pkg::MONTH_OCT)) |-> !n_summer_time)
        else $error("summer time flagged outside march to october");
`endif

endmodule

`default_nettype wire
